FILE: rtl/dtu_pkg.sv
// Shared constants and helpers for the decimal text to unsigned integer parser.
`timescale 1ns / 1ps
package dtu_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STAT_W  = 2;

  localparam logic [POS_W-1:0] MAX_LEN = 13'd4096;

  // width_mode codes
  localparam logic [MODE_W-1:0] MODE_16    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_32    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_64    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_64;

  // status codes
  localparam logic [STAT_W-1:0] ST_ALL      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONDIGIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_SPACE    = 2'd3;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] DIGIT_MAX = 8'd9;

  localparam logic [VALUE_W-1:0] MAX_16     = 64'h0000_0000_0000_FFFF;
  localparam logic [VALUE_W-1:0] MAX_32     = 64'h0000_0000_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] MAX_64     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] MAX_16_D10 = 64'd6553;
  localparam logic [VALUE_W-1:0] MAX_32_D10 = 64'd429496729;
  localparam logic [VALUE_W-1:0] MAX_64_D10 = 64'd1844674407370955161;

  function automatic logic is_space(input logic [7:0] c);
    logic r;
    r = (c == CHAR_SP) || (c inside {[CHAR_TAB:CHAR_CR]});
    return r;
  endfunction

endpackage

FILE: rtl/decimal_text_to_uint_saturating.sv
// Top level: byte-serial decimal text parser with saturation at 16, 32 or 64 bits.
// Registers: an accepted byte lands in the input reg; a last byte's result lands in the result reg.
// Throughput: one byte per cycle unless a last byte stalls; the accumulator multiply-by-ten,
// add and overflow compare are combinational, so back-to-back bytes and fields are taken.
// A finished result waits in the result register; a later last byte stalls until it is taken.
// Reset (rst_ni low, asynchronous): parser re-armed to skip whitespace, width_mode = 64 bits.
`timescale 1ns / 1ps
module decimal_text_to_uint_saturating (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    char_byte_i,
  input  logic                          is_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dtu_pkg::VALUE_W-1:0]   value_o,
  output logic [dtu_pkg::POS_W-1:0]     stop_offset_o,
  output logic [dtu_pkg::STAT_W-1:0]    status_o,
  input  logic                          cfg_we_i,
  input  logic [dtu_pkg::MODE_W-1:0]    cfg_wdata_i
);

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_DIGIT,
    PH_STOP
  } phase_e;

  logic [dtu_pkg::MODE_W-1:0]  mode_q;

  logic                        s1_valid_q;
  logic [7:0]                  s1_byte_q;
  logic                        s1_last_q;

  phase_e                      phase_q, phase_d;
  logic [dtu_pkg::VALUE_W-1:0] acc_q, acc_d;
  logic [dtu_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [dtu_pkg::POS_W-1:0]   spos_q, spos_d;
  logic [dtu_pkg::STAT_W-1:0]  sstat_q, sstat_d;

  logic                        out_valid_q;
  logic [dtu_pkg::VALUE_W-1:0] value_q, value_d;
  logic [dtu_pkg::POS_W-1:0]   off_q, off_d;
  logic [dtu_pkg::STAT_W-1:0]  stat_q, stat_d;

  logic                        out_free;
  logic                        s1_adv;
  logic                        in_acc;
  logic                        emit;

  logic [dtu_pkg::VALUE_W-1:0] maxv;
  logic [dtu_pkg::VALUE_W-1:0] maxv_d10;
  logic [7:0]                  digit;
  logic [dtu_pkg::VALUE_W-1:0] acc_x10;
  logic                        ovf;
  phase_e                      ph;

  assign out_free   = !out_valid_q || out_ready_i;
  // A last byte needs the result slot; other bytes always advance.
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign emit       = s1_adv && s1_last_q;

  always_comb begin
    case (mode_q)
      dtu_pkg::MODE_16: begin
        maxv     = dtu_pkg::MAX_16;
        maxv_d10 = dtu_pkg::MAX_16_D10;
      end
      dtu_pkg::MODE_32: begin
        maxv     = dtu_pkg::MAX_32;
        maxv_d10 = dtu_pkg::MAX_32_D10;
      end
      default: begin
        maxv     = dtu_pkg::MAX_64;
        maxv_d10 = dtu_pkg::MAX_64_D10;
      end
    endcase
  end

  assign digit   = s1_byte_q - dtu_pkg::CHAR_ZERO;
  assign acc_x10 = {acc_q[dtu_pkg::VALUE_W-4:0], 3'b000} +
                   {acc_q[dtu_pkg::VALUE_W-2:0], 1'b0};
  // acc_x10 is exact whenever acc_q is within maxv/10; otherwise the first term decides.
  assign ovf     = (acc_q > maxv_d10) ||
                   (acc_x10 > (maxv - {{(dtu_pkg::VALUE_W-8){1'b0}}, digit}));

  always_comb begin
    ph      = phase_q;
    acc_d   = acc_q;
    spos_d  = spos_q;
    sstat_d = sstat_q;

    if (ph == PH_SPACE && !dtu_pkg::is_space(s1_byte_q)) begin
      ph = PH_DIGIT;
    end

    if (ph == PH_DIGIT) begin
      if (digit > dtu_pkg::DIGIT_MAX) begin
        ph      = PH_STOP;
        spos_d  = pos_q;
        sstat_d = dtu_pkg::ST_NONDIGIT;
      end else if (ovf) begin
        ph      = PH_STOP;
        acc_d   = maxv;
        spos_d  = pos_q;
        sstat_d = dtu_pkg::ST_OVERFLOW;
      end else begin
        acc_d = acc_x10 + {{(dtu_pkg::VALUE_W-8){1'b0}}, digit};
      end
    end

    phase_d = ph;
    pos_d   = (pos_q < dtu_pkg::MAX_LEN) ? pos_q + dtu_pkg::POS_W'(1) : pos_q;

    // An accumulator above the current maximum only survives from a width change;
    // clamp it at emission.
    value_d = (acc_q > maxv) ? maxv : acc_d;
    case (ph)
      PH_SPACE: begin
        value_d = '0;
        off_d   = pos_d;
        stat_d  = dtu_pkg::ST_SPACE;
      end
      PH_DIGIT: begin
        off_d  = pos_d;
        stat_d = dtu_pkg::ST_ALL;
      end
      default: begin
        off_d  = spos_d;
        stat_d = sstat_d;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= dtu_pkg::MODE_RESET;
      s1_valid_q  <= 1'b0;
      phase_q     <= PH_SPACE;
      acc_q       <= '0;
      pos_q       <= '0;
      spos_q      <= '0;
      sstat_q     <= dtu_pkg::ST_ALL;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end

      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        if (s1_last_q) begin
          // re-arm for the next field
          phase_q <= PH_SPACE;
          acc_q   <= '0;
          pos_q   <= '0;
          spos_q  <= '0;
          sstat_q <= dtu_pkg::ST_ALL;
        end else begin
          phase_q <= phase_d;
          acc_q   <= acc_d;
          pos_q   <= pos_d;
          spos_q  <= spos_d;
          sstat_q <= sstat_d;
        end
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= char_byte_i;
      s1_last_q <= is_last_i;
    end
    if (emit) begin
      value_q <= value_d;
      off_q   <= off_d;
      stat_q  <= stat_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign stop_offset_o = off_q;
  assign status_o      = stat_q;

endmodule

FILE: tb/decimal_text_to_uint_saturating_tb.sv
// Self-checking testbench for the saturating decimal text to unsigned integer parser.
`timescale 1ns / 1ps
module decimal_text_to_uint_saturating_tb;
  import dtu_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 120;

  typedef struct packed {
    logic [7:0] c;
    logic       last;
  } text_byte_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   offset;
    logic [STAT_W-1:0]  status;
  } number_t;

  typedef enum logic [1:0] {SCAN_SPACE, SCAN_DIGIT, SCAN_DONE} scan_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           char_byte_i = 8'h00;
  logic                 is_last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [VALUE_W-1:0]   value_o;
  logic [POS_W-1:0]     stop_offset_o;
  logic [STAT_W-1:0]    status_o;
  logic                 cfg_we_i = 1'b0;
  logic [MODE_W-1:0]    cfg_wdata_i = MODE_RESET;

  text_byte_t text_bytes[$];
  number_t    numbers_due[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       hold_req = 1'b0;
  int         fail_count = 0;

  // parser mirror
  logic [MODE_W-1:0]  cur_mode = MODE_RESET;
  scan_e              scan = SCAN_SPACE;
  logic [VALUE_W-1:0] acc = '0;
  logic [POS_W-1:0]   char_pos = '0;
  logic [POS_W-1:0]   stop_pos = '0;
  logic [STAT_W-1:0]  stop_code = ST_ALL;

  decimal_text_to_uint_saturating u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_byte_i   (char_byte_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .stop_offset_o (stop_offset_o),
    .status_o      (status_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [VALUE_W-1:0] width_limit(input logic [MODE_W-1:0] m);
    case (m)
      MODE_16: return MAX_16;
      MODE_32: return MAX_32;
      default: return MAX_64;
    endcase
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return (c == CHAR_SP) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  // Advance the mirror by one byte; queue the number a marked byte yields.
  task automatic parse_char(input logic [7:0] c, input logic last);
    logic [VALUE_W-1:0] lim;
    logic [7:0]         d;
    number_t            r;
    lim = width_limit(cur_mode);
    if (scan == SCAN_SPACE && !blank(c)) scan = SCAN_DIGIT;
    if (scan == SCAN_DIGIT) begin
      d = c - CHAR_ZERO;
      if (d > DIGIT_MAX) begin
        scan = SCAN_DONE;
        stop_pos = char_pos;
        stop_code = ST_NONDIGIT;
      end else if (acc > lim / 10 || acc * 10 > lim - d) begin
        scan = SCAN_DONE;
        acc = lim;
        stop_pos = char_pos;
        stop_code = ST_OVERFLOW;
      end else begin
        acc = acc * 10 + d;
      end
    end
    if (char_pos < MAX_LEN) char_pos = char_pos + POS_W'(1);
    if (last) begin
      r.value = (acc > lim) ? lim : acc;
      case (scan)
        SCAN_SPACE: begin
          r.value = '0;
          r.offset = char_pos;
          r.status = ST_SPACE;
        end
        SCAN_DIGIT: begin
          r.offset = char_pos;
          r.status = ST_ALL;
        end
        default: begin
          r.offset = stop_pos;
          r.status = stop_code;
        end
      endcase
      numbers_due.push_back(r);
      scan = SCAN_SPACE;
      acc = '0;
      char_pos = '0;
      stop_pos = '0;
      stop_code = ST_ALL;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    text_byte_t nb;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      char_byte_i <= 8'h00;
      is_last_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) parse_char(char_byte_i, is_last_i);
      if (!in_valid_i || in_ready_o) begin
        if (text_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = text_bytes.pop_front();
          in_valid_i <= 1'b1;
          char_byte_i <= nb.c;
          is_last_i <= nb.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin : recv_proc
    int hold_left;
    if (!rst_ni) begin
      hold_left = 0;
      out_ready_i <= 1'b0;
    end else begin
      if (hold_req) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_proc
    number_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (numbers_due.size() == 0) begin
        $error("unexpected result: value %0d, stop_offset %0d, status %0d",
               value_o, stop_offset_o, status_o);
        fail_count++;
      end else begin
        want = numbers_due.pop_front();
        if (value_o !== want.value) begin
          $error("value: expected %0d, actual %0d", want.value, value_o);
          fail_count++;
        end
        if (stop_offset_o !== want.offset) begin
          $error("stop_offset: expected %0d, actual %0d", want.offset, stop_offset_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog_proc
    int quiet;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("decimal_text_to_uint_saturating regression: fail");
        $finish;
      end
    end
  end

  task automatic add_byte(input logic [7:0] c, input logic last);
    text_byte_t nb;
    nb.c = c;
    nb.last = last;
    text_bytes.push_back(nb);
  endtask

  task automatic add_text(input string s, input logic mark_last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], mark_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] any_space();
    if ($urandom_range(5) == 0) return CHAR_SP;
    return CHAR_TAB + 8'($urandom_range(4));
  endfunction

  // Queue one field; return its byte count, not counting any trailing random bytes.
  task automatic add_random_field(output int counted);
    logic [7:0] fb[$];
    logic [7:0] digs[$];
    string      num;
    int         kind;
    int         n;
    kind = $urandom_range(99);
    n = $urandom_range(3);
    repeat (n) fb.push_back(any_space());
    if (kind < 55) begin
      n = $urandom_range(1, 22);
      repeat (n) fb.push_back(CHAR_ZERO + 8'($urandom_range(9)));
    end else if (kind < 72) begin
      // numbers right around the width maximum
      num = $sformatf("%0d", width_limit(cur_mode));
      for (int i = 0; i < num.len(); i++) digs.push_back(num[i]);
      case ($urandom_range(4))
        0: ;
        1: digs[digs.size() - 1] = CHAR_ZERO + 8'($urandom_range(9));
        2: digs.push_back(CHAR_ZERO + 8'($urandom_range(9)));
        3: void'(digs.pop_back());
        default: repeat ($urandom_range(1, 3)) digs.push_front(CHAR_ZERO);
      endcase
      foreach (digs[i]) fb.push_back(digs[i]);
    end else if (kind < 82) begin
      if ($urandom_range(1) == 0) fb.push_back(any_space());
      else fb.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 8)) fb.push_back(8'($urandom_range(255)));
    end
    if (fb.size() == 0) fb.push_back(any_space());
    counted = fb.size();
    if ($urandom_range(9) < 3) repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom_range(255)));
    foreach (fb[i]) add_byte(fb[i], i == fb.size() - 1);
  endtask

  task automatic wait_idle();
    while (text_bytes.size() != 0 || in_valid_i || numbers_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [MODE_W-1:0] m);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    cur_mode = m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [MODE_W-1:0] phase_mode(input int p);
    case (p % 4)
      0: return MODE_16;
      1: return MODE_32;
      2: return MODE_64;
      default: return MODE_SPARE;
    endcase
  endfunction

  initial begin : stimulus
    int prof;
    int counted;
    int got;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset width
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_text(" \t\n", 1'b0);
    add_byte(8'h0B, 1'b0);
    add_byte(8'h0C, 1'b0);
    add_byte(CHAR_CR, 1'b0);
    add_text("9", 1'b1);
    add_byte(CHAR_SP, 1'b0);
    add_byte(CHAR_CR, 1'b1);
    add_text("4a", 1'b1);
    // narrow the width while a field is open: the held value gets clamped
    add_text("70000", 1'b0);
    write_width(MODE_16);
    add_byte(CHAR_SP, 1'b1);
    add_text("65536", 1'b1);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_width(phase_mode(p));
      prof = (p < 4) ? p : (p + 2) % 4;
      send_idle_pct <= (prof == 1) ? 83 : (prof == 3) ? 19 : 0;
      recv_stall_pct <= (prof == 2) ? 83 : (prof == 3) ? 19 : 0;
      got = 0;
      while (got < PHASE_ITEMS) begin
        add_random_field(counted);
        got += counted;
      end
      if (p == 4) begin
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("decimal_text_to_uint_saturating regression: pass");
    end else begin
      $display("decimal_text_to_uint_saturating regression: fail");
    end
    $finish;
  end

endmodule
